// File: sv/tpae_pkg.sv
// ----------------------------------------------------------------------------
// tpae_pkg
// Shared types and constants of the touch pad attack envelope block.
// ----------------------------------------------------------------------------
package tpae_pkg;

  // The pad ports are sized for four instrument pads plus the mode pad.
  localparam int INSTRUMENT_PADS = 4;

  localparam int DIV_STEPS = 16;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [16:0] Q_ONE     = 17'h10000;
  localparam logic [16:0] MAX_LEVEL = 17'd127;

  localparam logic [15:0] RST_TOUCH_THRESHOLD = 16'd60;
  localparam logic [15:0] RST_ATTACK_TIME     = 16'd500;
  localparam logic [15:0] RST_SEND_INTERVAL   = 16'd20;
  localparam logic [15:0] RST_MODE_DEBOUNCE   = 16'd600;

  typedef enum logic [1:0] {
    CFG_TOUCH_THRESHOLD = 2'd0,
    CFG_ATTACK_TIME     = 2'd1,
    CFG_SEND_INTERVAL   = 2'd2,
    CFG_MODE_DEBOUNCE   = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    KIND_LEVEL = 1'b0,
    KIND_MODE  = 1'b1
  } result_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_INT_DIV,
    ST_INT_WR,
    ST_REPORT,
    ST_RAMP,
    ST_RAMP_DIV,
    ST_RAMP_LD,
    ST_SQ,
    ST_PROD,
    ST_LEVEL,
    ST_EMIT_LEVEL,
    ST_EMIT_MODE
  } state_t;

  typedef struct packed {
    logic capture;
    logic mode_update;
    logic held_update;
    logic latch_start;
    logic div_start_int;
    logic div_start_ramp;
    logic div_step;
    logic int_write;
    logic report_mark;
    logic acc_full;
    logic acc_div;
    logic mul_sq;
    logic mul_prod;
    logic mul_level;
    logic out_load_level;
    logic out_load_mode;
  } dp_cmd_t;

  typedef struct packed {
    logic unused_pad;
    logic mode_pad;
    logic touching;
    logic held;
    logic toggle_ok;
    logic report_due;
    logic ramp_sat;
    logic out_free;
  } dp_status_t;

endpackage

// File: sv/touch_pad_attack_envelope.sv
// Flow: a mode report passes the decide and emit-mode states on its way to the
// output register; a level report passes the report, ramp, square, product and
// level states, and the shared 16-step divider for the intensity on a fresh
// touch and for the ramp while it rises. Both wait while the output is full. A
// sample with no result returns to idle. One request is handled at a time.
// Reset (synchronous): clears all pad state, the mode and loads default config.
// ----------------------------------------------------------------------------
// touch_pad_attack_envelope
// Capacitive pad sampler with per-pad attack envelope and a debounced mode pad.
// ----------------------------------------------------------------------------
module touch_pad_attack_envelope (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  pad_number,
  input  logic [15:0] raw_reading,
  input  logic [31:0] time_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [1:0]  pad_index,
  output logic [6:0]  level,
  output logic        mode,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  tpae_pkg::dp_cmd_t    cmd;
  tpae_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  tpae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tpae_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .pad_number  (pad_number),
    .raw_reading (raw_reading),
    .time_ms     (time_ms),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .result_kind (result_kind),
    .pad_index   (pad_index),
    .level       (level),
    .mode        (mode)
  );

  // An accepted request leaves the block busy in the cycle after it is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a request");

  // A new result is only loaded while a request is in flight.
  a_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with no request in flight");

  // Mode reports carry no pad and no level.
  a_mode_report_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind |-> pad_index == 2'd0 && level == 7'd0)
    else $error("mode report with pad or level set");

endmodule

// File: sv/tpae_dp.sv
// ----------------------------------------------------------------------------
// tpae_dp
// Datapath: configuration registers, per-pad state, shared restoring divider,
// shared 17x17 multiplier and the result register.
// ----------------------------------------------------------------------------
module tpae_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [2:0]           pad_number,
  input  logic [15:0]          raw_reading,
  input  logic [31:0]          time_ms,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  tpae_pkg::dp_cmd_t    cmd,
  output tpae_pkg::dp_status_t status,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 result_kind,
  output logic [1:0]           pad_index,
  output logic [6:0]           level,
  output logic                 mode
);

  localparam int NP = tpae_pkg::INSTRUMENT_PADS;

  logic [15:0] thr;
  logic [15:0] attack;
  logic [15:0] send_int;
  logic [15:0] debounce;

  logic [2:0]  pad_r;
  logic [15:0] raw_r;
  logic [31:0] now_r;

  logic [NP:0] held;
  logic [31:0] start    [NP];
  logic [16:0] intens   [NP];
  logic [31:0] last_rep [NP];
  logic [31:0] last_toggle;
  logic        cur_mode;

  logic [15:0] div_rem;
  logic [16:0] div_quo;
  logic [15:0] div_dvs;
  logic [16:0] acc;

  logic [NP:0] pad_sel;
  logic        touching;
  logic [31:0] start_sel;
  logic [31:0] last_rep_sel;
  logic [16:0] int_sel;
  logic [31:0] elapsed;
  logic [31:0] since_report;
  logic [31:0] since_toggle;

  logic [16:0] div_shift;
  logic        div_ge;
  logic [15:0] div_num;
  logic [15:0] div_den;
  logic        div_q16;

  logic [16:0] mul_a;
  logic [16:0] mul_b;
  logic [33:0] product;

  always_comb begin
    for (int i = 0; i <= NP; i++) begin
      pad_sel[i] = ({29'd0, pad_r} == 32'(i));
    end
    start_sel    = '0;
    last_rep_sel = '0;
    int_sel      = '0;
    for (int i = 0; i < NP; i++) begin
      start_sel    = start_sel    | ({32{pad_sel[i]}} & start[i]);
      last_rep_sel = last_rep_sel | ({32{pad_sel[i]}} & last_rep[i]);
      int_sel      = int_sel      | ({17{pad_sel[i]}} & intens[i]);
    end
  end

  assign touching     = raw_r < thr;
  assign elapsed      = now_r - start_sel;
  assign since_report = now_r - last_rep_sel;
  assign since_toggle = now_r - last_toggle;

  always_comb begin
    status.unused_pad = {29'd0, pad_r} > 32'(NP);
    status.mode_pad   = pad_sel[NP];
    status.touching   = touching;
    status.held       = |(held & pad_sel);
    status.toggle_ok  = since_toggle > {16'd0, debounce};
    status.report_due = since_report >= {16'd0, send_int};
    status.ramp_sat   = (elapsed >= {16'd0, attack}) || (attack == 16'd0);
    status.out_free   = !out_valid || out_ready;
  end

  // The numerator never exceeds the divisor, so the top quotient bit is
  // settled up front and the remainder stays below the divisor afterwards.
  assign div_num   = cmd.div_start_int ? (thr - raw_r) : elapsed[15:0];
  assign div_den   = cmd.div_start_int ? thr : attack;
  assign div_q16   = div_num >= div_den;
  assign div_shift = {div_rem, 1'b0};
  assign div_ge    = div_shift >= {1'b0, div_dvs};

  always_comb begin
    mul_a = acc;
    mul_b = acc;
    if (cmd.mul_prod) begin
      mul_b = int_sel;
    end else if (cmd.mul_level) begin
      mul_b = tpae_pkg::MAX_LEVEL;
    end
  end

  assign product = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr         <= tpae_pkg::RST_TOUCH_THRESHOLD;
      attack      <= tpae_pkg::RST_ATTACK_TIME;
      send_int    <= tpae_pkg::RST_SEND_INTERVAL;
      debounce    <= tpae_pkg::RST_MODE_DEBOUNCE;
      held        <= '0;
      last_toggle <= '0;
      cur_mode    <= 1'b0;
      out_valid   <= 1'b0;
      for (int i = 0; i < NP; i++) begin
        start[i]    <= '0;
        intens[i]   <= '0;
        last_rep[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (tpae_pkg::cfg_reg_t'(cfg_index))
          tpae_pkg::CFG_TOUCH_THRESHOLD: thr      <= cfg_data;
          tpae_pkg::CFG_ATTACK_TIME:     attack   <= cfg_data;
          tpae_pkg::CFG_SEND_INTERVAL:   send_int <= cfg_data;
          tpae_pkg::CFG_MODE_DEBOUNCE:   debounce <= cfg_data;
          default:                       thr      <= thr;
        endcase
      end
      for (int i = 0; i < NP; i++) begin
        if (pad_sel[i]) begin
          if (cmd.held_update) begin
            held[i] <= touching;
          end
          if (cmd.latch_start) begin
            start[i] <= now_r;
          end
          if (cmd.int_write) begin
            intens[i] <= div_quo;
          end
          if (cmd.report_mark) begin
            last_rep[i] <= now_r;
          end
        end
      end
      if (cmd.mode_update) begin
        if (touching) begin
          if (!held[NP]) begin
            held[NP] <= 1'b1;
            if (status.toggle_ok) begin
              last_toggle <= now_r;
              cur_mode    <= ~cur_mode;
            end
          end
        end else begin
          held[NP] <= 1'b0;
        end
      end
      if (cmd.out_load_level || cmd.out_load_mode) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pad_r <= pad_number;
      raw_r <= raw_reading;
      now_r <= time_ms;
    end
    if (cmd.div_start_int || cmd.div_start_ramp) begin
      div_rem <= div_q16 ? (div_num - div_den) : div_num;
      div_quo <= {16'd0, div_q16};
      div_dvs <= div_den;
    end else if (cmd.div_step) begin
      div_rem <= div_ge ? 16'(div_shift - {1'b0, div_dvs}) : div_shift[15:0];
      div_quo <= {div_quo[15:0], div_ge};
    end
    if (cmd.acc_full) begin
      acc <= tpae_pkg::Q_ONE;
    end else if (cmd.acc_div) begin
      acc <= div_quo;
    end else if (cmd.mul_sq || cmd.mul_prod) begin
      acc <= product[32:16];
    end else if (cmd.mul_level) begin
      acc <= {10'd0, product[22:16]};
    end
    if (cmd.out_load_level) begin
      result_kind <= tpae_pkg::KIND_LEVEL;
      pad_index   <= pad_r[1:0];
      level       <= acc[6:0];
      mode        <= cur_mode;
    end else if (cmd.out_load_mode) begin
      result_kind <= tpae_pkg::KIND_MODE;
      pad_index   <= 2'd0;
      level       <= 7'd0;
      mode        <= cur_mode;
    end
  end

endmodule

// File: sv/tpae_ctrl.sv
// ----------------------------------------------------------------------------
// tpae_ctrl
// Controller: sequences one sample through decision and, as the sample needs,
// divisions, multiplies and hand-off to the result register.
// ----------------------------------------------------------------------------
module tpae_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tpae_pkg::dp_status_t status,
  output tpae_pkg::dp_cmd_t    cmd
);

  tpae_pkg::state_t              state;
  tpae_pkg::state_t              state_next;
  logic [tpae_pkg::CNT_W-1:0]    cnt;
  logic [tpae_pkg::CNT_W-1:0]    cnt_next;
  logic                          cnt_last;

  assign in_ready = (state == tpae_pkg::ST_IDLE);
  assign cnt_last = (cnt == tpae_pkg::CNT_W'(tpae_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpae_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    cmd         = '0;
    cmd.capture = in_valid && in_ready;
    unique case (state)
      tpae_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = tpae_pkg::ST_DECIDE;
        end
      end
      tpae_pkg::ST_DECIDE: begin
        if (status.unused_pad) begin
          state_next = tpae_pkg::ST_IDLE;
        end else if (status.mode_pad) begin
          cmd.mode_update = 1'b1;
          if (status.touching && !status.held && status.toggle_ok) begin
            state_next = tpae_pkg::ST_EMIT_MODE;
          end else begin
            state_next = tpae_pkg::ST_IDLE;
          end
        end else begin
          cmd.held_update = 1'b1;
          if (status.touching && !status.held) begin
            // A fresh touch latches its start time and its intensity.
            cmd.latch_start   = 1'b1;
            cmd.div_start_int = 1'b1;
            cnt_next          = '0;
            state_next        = tpae_pkg::ST_INT_DIV;
          end else if (status.touching) begin
            state_next = tpae_pkg::ST_REPORT;
          end else begin
            state_next = tpae_pkg::ST_IDLE;
          end
        end
      end
      tpae_pkg::ST_INT_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt_last) begin
          state_next = tpae_pkg::ST_INT_WR;
        end
      end
      tpae_pkg::ST_INT_WR: begin
        cmd.int_write = 1'b1;
        state_next    = tpae_pkg::ST_REPORT;
      end
      tpae_pkg::ST_REPORT: begin
        if (status.report_due) begin
          cmd.report_mark = 1'b1;
          state_next      = tpae_pkg::ST_RAMP;
        end else begin
          state_next = tpae_pkg::ST_IDLE;
        end
      end
      tpae_pkg::ST_RAMP: begin
        if (status.ramp_sat) begin
          cmd.acc_full = 1'b1;
          state_next   = tpae_pkg::ST_SQ;
        end else begin
          cmd.div_start_ramp = 1'b1;
          cnt_next           = '0;
          state_next         = tpae_pkg::ST_RAMP_DIV;
        end
      end
      tpae_pkg::ST_RAMP_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt_last) begin
          state_next = tpae_pkg::ST_RAMP_LD;
        end
      end
      tpae_pkg::ST_RAMP_LD: begin
        cmd.acc_div = 1'b1;
        state_next  = tpae_pkg::ST_SQ;
      end
      tpae_pkg::ST_SQ: begin
        cmd.mul_sq = 1'b1;
        state_next = tpae_pkg::ST_PROD;
      end
      tpae_pkg::ST_PROD: begin
        cmd.mul_prod = 1'b1;
        state_next   = tpae_pkg::ST_LEVEL;
      end
      tpae_pkg::ST_LEVEL: begin
        cmd.mul_level = 1'b1;
        state_next    = tpae_pkg::ST_EMIT_LEVEL;
      end
      tpae_pkg::ST_EMIT_LEVEL: begin
        if (status.out_free) begin
          cmd.out_load_level = 1'b1;
          state_next         = tpae_pkg::ST_IDLE;
        end
      end
      tpae_pkg::ST_EMIT_MODE: begin
        if (status.out_free) begin
          cmd.out_load_mode = 1'b1;
          state_next        = tpae_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tpae_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
